>>> sv/ptds_pkg.sv
`default_nettype none

package ptds_pkg;

  localparam int OFFSET_W    = 31;
  localparam int MAXD_W      = 34;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 34;
  // quotient bits worked out; anything wider is clipped
  localparam int Q_W         = MAXD_W + 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_A       = 3'd0,
    REG_PLANE_B       = 3'd1,
    REG_PLANE_C       = 3'd2,
    REG_PLANE_OFFSET  = 3'd3,
    REG_MAX_DISTANCE2 = 3'd4
  } ptds_reg_t;

endpackage

`default_nettype wire

>>> sv/ptds_if.sv
`default_nettype none

interface ptds_cfg_if import ptds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ptds_point_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic                          last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface ptds_result_if import ptds_pkg::*; #(parameter int SUM_WIDTH = 48) ();
  logic                 valid;
  logic                 ready;
  logic [MAXD_W-1:0]    clipped_distance2;
  logic [SUM_WIDTH-1:0] running_sum;
  logic                 sum_final;
  logic                 degenerate_plane;

  modport source (output valid, clipped_distance2, running_sum, sum_final,
                  degenerate_plane, input ready);
  modport sink   (input valid, clipped_distance2, running_sum, sum_final,
                  degenerate_plane, output ready);
endinterface

`default_nettype wire

>>> sv/plane_truncated_distance_sum.sv
// Truncated squared point-to-plane distance score.
// cfg:     register writes (index, data), always ready. Write only while idle.
//          0 plane_a, 1 plane_b, 2 plane_c, 3 plane_offset, 4 max_distance2.
// points:  one request per point (x, y, z, last_point).
// results: one request per point: clipped squared distance, saturating running
//          sum, end-of-set flag and zero-normal flag.
// One signed multiplier with accumulator forms n = a*a+b*b+c*c, then
// dt = a*x+b*y+c*z+d, then dt*dt from three half-width products.
// A restoring divider then gives one quotient bit a cycle, after a single
// compare that catches quotients too big to matter.
// The divider is skipped when the normal is zero or the quotient is clipped
// early. points.ready is high only between items, so a new point is taken
// only once the previous one has reached the result register.
// The result register frees the core: the next point is taken while a result
// waits; a stalled receiver holds the block only once the next result is due.
// Reset: coefficients 0, 0, 1, offset 0, clip level all ones, sum cleared,
// no result pending. The sum clears after a result flagged last_point.
`default_nettype none

module plane_truncated_distance_sum
  import ptds_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 12,
  parameter int SUM_WIDTH   = 48
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ptds_cfg_if.sink     cfg,
  ptds_point_if.sink   points,
  ptds_result_if.source results
);

  localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
  localparam int DT_W   = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 2;
  localparam int HALF   = (DT_W + 1) / 2;
  localparam int HI_W   = DT_W - HALF;
  localparam int MULW0  = (COEF_WIDTH > COORD_WIDTH) ? COEF_WIDTH : COORD_WIDTH;
  localparam int MULW   = (MULW0 > HALF + 1) ? MULW0 : HALF + 1;
  localparam int SQ_W   = 2 * DT_W;
  localparam int ACC_W  = SQ_W + 1;
  localparam int N_W    = 2 * COEF_WIDTH;
  localparam int HIGH_W = SQ_W - Q_W;
  localparam int CMP_W  = (HIGH_W > N_W) ? HIGH_W : N_W;
  localparam int CNT_W  = $clog2(Q_W);

  typedef enum logic [3:0] {
    S_IDLE, S_N0, S_N1, S_N2, S_D0, S_D1, S_D2, S_Q0, S_Q1, S_Q2,
    S_PRE, S_DIV, S_CLIP, S_DONE
  } state_t;

  state_t state;

  logic signed [COEF_WIDTH-1:0]  plane_a, plane_b, plane_c;
  logic signed [OFFSET_W-1:0]    plane_offset;
  logic        [MAXD_W-1:0]      max_distance2;

  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic                          last;
  logic signed [ACC_W-1:0]       acc;
  logic        [N_W-1:0]         n;
  logic        [DT_W-1:0]        mag;
  logic        [SQ_W-1:0]        sq;
  logic        [N_W-1:0]         rem;
  logic        [Q_W-1:0]         dvd;
  logic        [CNT_W-1:0]       cnt;
  logic        [MAXD_W-1:0]      distance;
  logic                          degenerate;
  logic        [SUM_WIDTH-1:0]   accumulated_sum;

  logic                          res_valid;
  logic        [MAXD_W-1:0]      res_dist;
  logic        [SUM_WIDTH-1:0]   res_sum;
  logic                          res_final;
  logic                          res_degenerate;

  logic signed [MULW-1:0]        op_a, op_b;
  logic signed [2*MULW-1:0]      prod;
  logic        [CNT_W-1:0]       sh;
  logic signed [ACC_W-1:0]       base;
  logic signed [ACC_W-1:0]       term;
  logic signed [ACC_W-1:0]       acc_next;
  logic        [DT_W-1:0]        mag_next;
  logic        [HALF-1:0]        mag_lo;
  logic        [HI_W-1:0]        mag_hi;
  logic        [N_W:0]           rem_shift;
  logic        [N_W:0]           n_ext;
  logic                          rem_ge;
  logic        [CMP_W-1:0]       high_cmp, n_cmp;
  logic        [SUM_WIDTH:0]     sum_ext;
  logic        [SUM_WIDTH-1:0]   sum_next;

  assign mag_lo = mag[HALF-1:0];
  assign mag_hi = mag[DT_W-1:HALF];

  // shared multiply-accumulate
  always_comb begin
    op_a = '0;
    op_b = '0;
    sh   = '0;
    base = acc;
    unique case (state)
      S_N0: begin
        op_a = MULW'(plane_a);
        op_b = MULW'(plane_a);
        base = '0;
      end
      S_N1: begin
        op_a = MULW'(plane_b);
        op_b = MULW'(plane_b);
      end
      S_N2: begin
        op_a = MULW'(plane_c);
        op_b = MULW'(plane_c);
      end
      S_D0: begin
        op_a = MULW'(plane_a);
        op_b = MULW'(px);
        base = ACC_W'(plane_offset);
      end
      S_D1: begin
        op_a = MULW'(plane_b);
        op_b = MULW'(py);
      end
      S_D2: begin
        op_a = MULW'(plane_c);
        op_b = MULW'(pz);
      end
      S_Q0: begin
        op_a = MULW'(mag_lo);
        op_b = MULW'(mag_lo);
        base = '0;
      end
      S_Q1: begin
        op_a = MULW'(mag_hi);
        op_b = MULW'(mag_lo);
        sh   = CNT_W'(HALF + 1);
      end
      S_Q2: begin
        op_a = MULW'(mag_hi);
        op_b = MULW'(mag_hi);
        sh   = CNT_W'(2 * HALF);
      end
      default: begin
      end
    endcase
    prod     = op_a * op_b;
    term     = ACC_W'(prod) <<< sh;
    acc_next = base + term;
    mag_next = acc_next[ACC_W-1] ? DT_W'(-acc_next) : DT_W'(acc_next);
  end

  // divider step and sum
  always_comb begin
    rem_shift = {rem, dvd[Q_W-1]};
    n_ext     = {1'b0, n};
    rem_ge    = (rem_shift >= n_ext);
    high_cmp  = CMP_W'(sq[SQ_W-1:Q_W]);
    n_cmp     = CMP_W'(n);
    sum_ext   = {1'b0, accumulated_sum} + (SUM_WIDTH + 1)'(distance);
    sum_next  = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
  end

  assign cfg.ready    = 1'b1;
  assign points.ready = (state == S_IDLE);

  assign results.valid             = res_valid;
  assign results.clipped_distance2 = res_dist;
  assign results.running_sum       = res_sum;
  assign results.sum_final         = res_final;
  assign results.degenerate_plane  = res_degenerate;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      res_valid       <= 1'b0;
      accumulated_sum <= '0;
      plane_a         <= '0;
      plane_b         <= '0;
      plane_c         <= COEF_WIDTH'(1);
      plane_offset    <= '0;
      max_distance2   <= '1;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_PLANE_A:       plane_a       <= cfg.data[COEF_WIDTH-1:0];
          REG_PLANE_B:       plane_b       <= cfg.data[COEF_WIDTH-1:0];
          REG_PLANE_C:       plane_c       <= cfg.data[COEF_WIDTH-1:0];
          REG_PLANE_OFFSET:  plane_offset  <= cfg.data[OFFSET_W-1:0];
          REG_MAX_DISTANCE2: max_distance2 <= cfg.data[MAXD_W-1:0];
          default: begin
          end
        endcase
      end

      if (res_valid && results.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (points.valid) begin
            px    <= points.point_x;
            py    <= points.point_y;
            pz    <= points.point_z;
            last  <= points.last_point;
            state <= S_N0;
          end
        end
        S_N0: begin
          acc   <= acc_next;
          state <= S_N1;
        end
        S_N1: begin
          acc   <= acc_next;
          state <= S_N2;
        end
        S_N2: begin
          n     <= acc_next[N_W-1:0];
          state <= S_D0;
        end
        S_D0: begin
          acc   <= acc_next;
          state <= S_D1;
        end
        S_D1: begin
          acc   <= acc_next;
          state <= S_D2;
        end
        S_D2: begin
          mag   <= mag_next;
          state <= S_Q0;
        end
        S_Q0: begin
          acc   <= acc_next;
          state <= S_Q1;
        end
        S_Q1: begin
          acc   <= acc_next;
          state <= S_Q2;
        end
        S_Q2: begin
          sq    <= acc_next[SQ_W-1:0];
          state <= S_PRE;
        end
        S_PRE: begin
          degenerate <= (n == '0);
          if (n == '0 || high_cmp >= n_cmp) begin
            distance <= max_distance2;
            state    <= S_DONE;
          end else begin
            rem   <= N_W'(sq[SQ_W-1:Q_W]);
            dvd   <= sq[Q_W-1:0];
            cnt   <= CNT_W'(Q_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? N_W'(rem_shift - n_ext) : rem_shift[N_W-1:0];
          dvd <= {dvd[Q_W-2:0], rem_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          distance <= (dvd > {1'b0, max_distance2}) ? max_distance2 : dvd[MAXD_W-1:0];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || results.ready) begin
            res_valid       <= 1'b1;
            res_dist        <= distance;
            res_sum         <= sum_next;
            res_final       <= last;
            res_degenerate  <= degenerate;
            accumulated_sum <= last ? '0 : sum_next;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
